>>> sv/tcnd_pkg.sv
// ----------------------------------------------------------------------------
// tcnd_pkg
// Shared types and constants for the two-lift nearest dispatcher.
// ----------------------------------------------------------------------------
package tcnd_pkg;

  // transaction kind on the input channel
  typedef enum logic [1:0] {
    MODE_REQUEST  = 2'd0,
    MODE_LIFT_ONE = 2'd1,
    MODE_LIFT_TWO = 2'd2
  } mode_e;

  // code with no meaning, answered with an all-zero result
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic {
    LIFT_ONE = 1'b0,
    LIFT_TWO = 1'b1
  } lift_e;

  localparam int unsigned SentFloorW = 8;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

>>> sv/tcnd_fifo.sv
// ----------------------------------------------------------------------------
// tcnd_fifo
// Request queue: memory with one write and one registered read port. The
// read port always fetches the entry at the next head pointer, so the head
// floor is ready in a register in the cycle after any push or pop.
// ----------------------------------------------------------------------------
module tcnd_fifo #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcnd_pkg::fifo_ctrl_t   ctrl_i,
  input  logic [WIDTH-1:0]       wdata_i,
  output logic [WIDTH-1:0]       head_o,
  output tcnd_pkg::fifo_stat_t   stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    head_d  = ctrl_i.pop ? ptr_inc(head_q) : head_q;
    tail_d  = ctrl_i.push ? ptr_inc(tail_q) : tail_q;
    count_d = count_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // write port and registered read with write bypass
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= wdata_i;
    end
    if (ctrl_i.push && (tail_q == head_d)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[head_d];
    end
  end

  assign head_o       = rdata_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);

endmodule

>>> sv/two_car_nearest_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// two_car_nearest_dispatcher_unit
// Dispatcher for two lifts with a floor request queue.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one transaction is either a floor
// request (mode 0) or a status report from lift one or lift two (modes 1, 2).
// Output channel (out_valid_o / out_stall_i): exactly one result transaction
// per input transaction, in order: a dispatch (lift and floor), a dropped
// request flag when the queue was full, or all zeros.
// The result is registered: it is in the output register in the cycle
// after the input is accepted. Throughput is one transaction per cycle while
// the receiver does not stall; the queue read port refetches the head every
// cycle, so a pop is followed at once by a valid new head.
// The very first request after reset goes to lift one in its own cycle.
// When the receiver stalls, the held result stays stable and the input is
// stalled as well; a new input is accepted in the same cycle that the held
// result is taken.
// Reset: the queue is empty, both lifts free, both last destinations at
// floor 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_car_nearest_dispatcher_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned FLOOR_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [FLOOR_BITS-1:0]               floor_i,
  input  logic                                lift_free_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                dispatch_valid_o,
  output logic                                target_lift_o,
  output logic [tcnd_pkg::SentFloorW-1:0]     sent_floor_o,
  output logic                                request_dropped_o
);

  localparam int unsigned OutW = tcnd_pkg::SentFloorW;

  logic                  in_fire;
  tcnd_pkg::fifo_ctrl_t  fifo_ctrl;
  tcnd_pkg::fifo_stat_t  fifo_stat;
  logic [FLOOR_BITS-1:0] head_floor;

  logic                  first_q, first_d;
  logic                  free1_q, free1_d;
  logic                  free2_q, free2_d;
  logic [FLOOR_BITS-1:0] dest1_q, dest1_d;
  logic [FLOOR_BITS-1:0] dest2_q, dest2_d;
  logic [FLOOR_BITS-1:0] dist1, dist2;

  logic                  res_disp;
  logic                  res_lift;
  logic [FLOOR_BITS-1:0] res_floor;
  logic                  res_drop;
  logic [FLOOR_BITS+OutW-1:0] res_floor_ext;

  logic                  out_valid_q, out_valid_d;
  logic                  disp_q;
  logic                  lift_q;
  logic [OutW-1:0]       floor_q;
  logic                  drop_q;

  function automatic logic [FLOOR_BITS-1:0] abs_diff(input logic [FLOOR_BITS-1:0] a,
                                                     input logic [FLOOR_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  tcnd_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (FLOOR_BITS)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .wdata_i (floor_i),
    .head_o  (head_floor),
    .stat_o  (fifo_stat)
  );

  assign dist1 = abs_diff(head_floor, dest1_q);
  assign dist2 = abs_diff(head_floor, dest2_q);

  always_comb begin
    first_d        = first_q;
    free1_d        = free1_q;
    free2_d        = free2_q;
    dest1_d        = dest1_q;
    dest2_d        = dest2_q;
    fifo_ctrl.push = 1'b0;
    fifo_ctrl.pop  = 1'b0;
    res_disp       = 1'b0;
    res_lift       = tcnd_pkg::LIFT_ONE;
    res_floor      = '0;
    res_drop       = 1'b0;
    if (in_fire) begin
      case (tcnd_pkg::mode_e'(mode_i))
        tcnd_pkg::MODE_REQUEST: begin
          if (fifo_stat.full) begin
            res_drop = 1'b1;
          end else if (first_q) begin
            // first request bypasses the queue
            first_d   = 1'b0;
            dest1_d   = floor_i;
            res_disp  = 1'b1;
            res_floor = floor_i;
          end else begin
            fifo_ctrl.push = 1'b1;
          end
        end
        tcnd_pkg::MODE_LIFT_ONE: begin
          free1_d = lift_free_i;
          if (lift_free_i && !fifo_stat.empty) begin
            if (dist1 <= dist2) begin
              res_disp = 1'b1;
              res_lift = tcnd_pkg::LIFT_ONE;
            end else if (free2_q) begin
              res_disp = 1'b1;
              res_lift = tcnd_pkg::LIFT_TWO;
            end
          end
        end
        tcnd_pkg::MODE_LIFT_TWO: begin
          free2_d = lift_free_i;
          if (lift_free_i && !fifo_stat.empty) begin
            if (dist1 >= dist2) begin
              res_disp = 1'b1;
              res_lift = tcnd_pkg::LIFT_TWO;
            end else if (free1_q) begin
              res_disp = 1'b1;
              res_lift = tcnd_pkg::LIFT_ONE;
            end
          end
        end
        default: begin
        end
      endcase
      // queued dispatch pops the head
      if (res_disp && (tcnd_pkg::mode_e'(mode_i) != tcnd_pkg::MODE_REQUEST)) begin
        fifo_ctrl.pop = 1'b1;
        res_floor     = head_floor;
        if (res_lift == tcnd_pkg::LIFT_ONE) begin
          dest1_d = head_floor;
        end else begin
          dest2_d = head_floor;
        end
      end
    end
  end

  assign res_floor_ext = {{OutW{1'b0}}, res_floor};
  assign out_valid_d   = in_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      free1_q     <= 1'b1;
      free2_q     <= 1'b1;
      dest1_q     <= '0;
      dest2_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      free1_q     <= free1_d;
      free2_q     <= free2_d;
      dest1_q     <= dest1_d;
      dest2_q     <= dest2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      disp_q  <= res_disp;
      lift_q  <= res_lift;
      floor_q <= res_floor_ext[OutW-1:0];
      drop_q  <= res_drop;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign dispatch_valid_o  = disp_q;
  assign target_lift_o     = lift_q;
  assign sent_floor_o      = floor_q;
  assign request_dropped_o = drop_q;

endmodule

>>> sv/tcnd_checker.sv
// ----------------------------------------------------------------------------
// tcnd_checker
// Port-level checks for the two-lift dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module tcnd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [1:0]                      mode_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            dispatch_valid_o,
  input logic                            target_lift_o,
  input logic [tcnd_pkg::SentFloorW-1:0] sent_floor_o,
  input logic                            request_dropped_o
);

  // stalled result transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // every accepted transaction gives a result next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction without result");

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(dispatch_valid_o && request_dropped_o))
    else $error("dispatch and drop in one result");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dispatch_valid_o |-> (target_lift_o == tcnd_pkg::LIFT_ONE)
      && (sent_floor_o == '0))
    else $error("non-dispatch result carries lift or floor");

  a_unused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == tcnd_pkg::MODE_UNUSED) |=>
      !dispatch_valid_o && !request_dropped_o)
    else $error("unused mode produced a dispatch or drop");

endmodule

bind two_car_nearest_dispatcher_unit tcnd_checker u_tcnd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .mode_i            (mode_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .dispatch_valid_o  (dispatch_valid_o),
  .target_lift_o     (target_lift_o),
  .sent_floor_o      (sent_floor_o),
  .request_dropped_o (request_dropped_o)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-lift nearest dispatcher. A short table of
// hand-picked transactions (unused mode, busy report, first request, full
// queue) is followed by random phases that lean toward filling or draining
// the request queue. Every input accepted on the valid/stall channel runs
// through a behavioral copy of the dispatcher, and each result is compared
// field by field in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int QDEPTH      = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int IDLE_LIMIT  = 1000;

  typedef struct packed {
    logic            disp;
    tcnd_pkg::lift_e lift;
    logic [7:0]      flr;
    logic            dropped;
  } disp_result_t;

  typedef struct {
    logic [1:0]   mode;
    logic [7:0]   flr;
    logic         free;
    bit           fixed;
    disp_result_t res;
  } stim_row_t;

  localparam disp_result_t NO_DISPATCH = '0;
  localparam disp_result_t DROPPED_RES = '{disp: 1'b0, lift: tcnd_pkg::LIFT_ONE,
                                           flr: 8'h00, dropped: 1'b1};
  localparam disp_result_t FIRST_RES   = '{disp: 1'b1, lift: tcnd_pkg::LIFT_ONE,
                                           flr: 8'hFF, dropped: 1'b0};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] mode_i = tcnd_pkg::MODE_REQUEST;
  logic [7:0] floor_i = '0;
  logic       lift_free_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       dispatch_valid_o;
  logic       target_lift_o;
  logic [7:0] sent_floor_o;
  logic       request_dropped_o;

  two_car_nearest_dispatcher_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .floor_i           (floor_i),
    .lift_free_i       (lift_free_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .dispatch_valid_o  (dispatch_valid_o),
    .target_lift_o     (target_lift_o),
    .sent_floor_o      (sent_floor_o),
    .request_dropped_o (request_dropped_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // dispatcher state mirrored by the predictor
  logic [7:0] fifo_mem [QDEPTH];
  logic [3:0] fifo_head = '0;
  logic [3:0] fifo_tail = '0;
  int         fifo_cnt = 0;
  logic       first_req = 1'b1;
  logic       one_free = 1'b1;
  logic       two_free = 1'b1;
  logic [7:0] one_dest = '0;
  logic [7:0] two_dest = '0;

  disp_result_t pending_res[$];
  stim_row_t    dir_rows[$];

  bit           cur_fixed = 1'b0;
  disp_result_t cur_fixed_res = '0;
  bit           quiet_send = 1'b0;
  bit           quiet_recv = 1'b0;
  int           hold_left = 0;
  int           acc_cnt = 0;
  int           res_cnt = 0;
  int           idle_cycles = 0;
  int           err_cnt = 0;
  int           to_one = 0;
  int           to_two = 0;
  int           drop_cnt = 0;

  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  function automatic disp_result_t pop_to(tcnd_pkg::lift_e which);
    disp_result_t r;
    r = '0;
    r.disp = 1'b1;
    r.lift = which;
    r.flr  = fifo_mem[fifo_head];
    if (which == tcnd_pkg::LIFT_ONE) one_dest = r.flr;
    else two_dest = r.flr;
    fifo_head++;
    fifo_cnt--;
    return r;
  endfunction

  function automatic disp_result_t predict_dispatch(logic [1:0] m, logic [7:0] f, logic fr);
    disp_result_t r;
    int           hd;
    int           d_one;
    int           d_two;
    r = '0;
    case (m)
      tcnd_pkg::MODE_REQUEST: begin
        if (fifo_cnt >= QDEPTH) begin
          r.dropped = 1'b1;
        end else begin
          fifo_mem[fifo_tail] = f;
          fifo_tail++;
          fifo_cnt++;
          if (first_req) begin
            first_req = 1'b0;
            r = pop_to(tcnd_pkg::LIFT_ONE);
          end
        end
      end
      tcnd_pkg::MODE_LIFT_ONE, tcnd_pkg::MODE_LIFT_TWO: begin
        if (m == tcnd_pkg::MODE_LIFT_ONE) one_free = fr;
        else two_free = fr;
        if (fr && fifo_cnt != 0) begin
          hd    = int'(fifo_mem[fifo_head]);
          d_one = hd >= int'(one_dest) ? hd - int'(one_dest) : int'(one_dest) - hd;
          d_two = hd >= int'(two_dest) ? hd - int'(two_dest) : int'(two_dest) - hd;
          if (m == tcnd_pkg::MODE_LIFT_ONE) begin
            if (d_one <= d_two) r = pop_to(tcnd_pkg::LIFT_ONE);
            else if (two_free) r = pop_to(tcnd_pkg::LIFT_TWO);
          end else begin
            if (d_one >= d_two) r = pop_to(tcnd_pkg::LIFT_TWO);
            else if (one_free) r = pop_to(tcnd_pkg::LIFT_ONE);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] m, logic [7:0] f, logic fr, bit fx,
                                       disp_result_t r);
    stim_row_t row;
    row.mode  = m;
    row.flr   = f;
    row.free  = fr;
    row.fixed = fx;
    row.res   = r;
    return row;
  endfunction

  // one transaction on the input channel, returns at the negedge after acceptance
  task automatic send_txn(logic [1:0] m, logic [7:0] f, logic fr, bit fx, disp_result_t r);
    int gap;
    int my_idx;
    gap = quiet_send ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    my_idx        = acc_cnt;
    cur_fixed     = fx;
    cur_fixed_res = r;
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    floor_i      <= f;
    lift_free_i  <= fr;
    do @(negedge clk_i); while (acc_cnt == my_idx);
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= (hold_left > 0);
      if (hold_left > 0 && out_valid_o) hold_left--;
    end
  end

  // result check, input prediction and watchdog
  always @(posedge clk_i) begin
    disp_result_t want;
    disp_result_t got;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got = '{disp: dispatch_valid_o, lift: tcnd_pkg::lift_e'(target_lift_o),
                flr: sent_floor_o, dropped: request_dropped_o};
        if (pending_res.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", res_cnt));
        end else begin
          want = pending_res.pop_front();
          if (got.disp !== want.disp)
            report_error($sformatf("result %0d dispatch_valid: expected %0b got %0b",
                                   res_cnt, want.disp, got.disp));
          if (got.lift !== want.lift)
            report_error($sformatf("result %0d target_lift: expected %0b got %0b",
                                   res_cnt, want.lift, got.lift));
          if (got.flr !== want.flr)
            report_error($sformatf("result %0d sent_floor: expected %0d got %0d",
                                   res_cnt, want.flr, got.flr));
          if (got.dropped !== want.dropped)
            report_error($sformatf("result %0d request_dropped: expected %0b got %0b",
                                   res_cnt, want.dropped, got.dropped));
        end
        if (got.disp === 1'b1 && got.lift == tcnd_pkg::LIFT_ONE) to_one++;
        if (got.disp === 1'b1 && got.lift == tcnd_pkg::LIFT_TWO) to_two++;
        if (got.dropped === 1'b1) drop_cnt++;
        res_cnt++;
        hold_left = quiet_recv ? 0 : $urandom_range(0, 6);
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        want = predict_dispatch(mode_i, floor_i, lift_free_i);
        pending_res.push_back(cur_fixed ? cur_fixed_res : want);
        acc_cnt++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] fill_floors [16];
    logic [1:0] m;
    logic [7:0] f;
    logic       fr;
    int         r;
    int         req_pct;

    fill_floors = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                    8'h10, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h02, 8'h40, 8'hC0};

    dir_rows.push_back(mk_row(tcnd_pkg::MODE_UNUSED,   8'hFF, 1'b1, 1'b1, NO_DISPATCH));
    dir_rows.push_back(mk_row(tcnd_pkg::MODE_LIFT_TWO, 8'h00, 1'b0, 1'b1, NO_DISPATCH));
    dir_rows.push_back(mk_row(tcnd_pkg::MODE_REQUEST,  8'hFF, 1'b0, 1'b1, FIRST_RES));
    dir_rows.push_back(mk_row(tcnd_pkg::MODE_REQUEST,  8'h00, 1'b1, 1'b1, NO_DISPATCH));
    // lift two is nearer but busy, then reports free
    dir_rows.push_back(mk_row(tcnd_pkg::MODE_LIFT_ONE, 8'h00, 1'b1, 1'b0, NO_DISPATCH));
    dir_rows.push_back(mk_row(tcnd_pkg::MODE_LIFT_TWO, 8'hFF, 1'b1, 1'b0, NO_DISPATCH));
    foreach (fill_floors[i])
      dir_rows.push_back(mk_row(tcnd_pkg::MODE_REQUEST, fill_floors[i], i[0], 1'b0,
                                NO_DISPATCH));
    dir_rows.push_back(mk_row(tcnd_pkg::MODE_REQUEST,  8'h5A, 1'b1, 1'b1, DROPPED_RES));
    dir_rows.push_back(mk_row(tcnd_pkg::MODE_LIFT_ONE, 8'h00, 1'b1, 1'b0, NO_DISPATCH));
    dir_rows.push_back(mk_row(tcnd_pkg::MODE_LIFT_TWO, 8'h00, 1'b1, 1'b0, NO_DISPATCH));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_txn(dir_rows[i].mode, dir_rows[i].flr, dir_rows[i].free, dir_rows[i].fixed,
               dir_rows[i].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      req_pct    = ph[0] ? 30 : 70;
      quiet_send = ($urandom_range(0, 3) == 0);
      quiet_recv = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r >= 97) m = tcnd_pkg::MODE_UNUSED;
        else if (r < req_pct) m = tcnd_pkg::MODE_REQUEST;
        else m = $urandom_range(0, 1) ? tcnd_pkg::MODE_LIFT_ONE : tcnd_pkg::MODE_LIFT_TWO;
        if ($urandom_range(0, 7) == 0) f = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else f = 8'($urandom);
        fr = ($urandom_range(0, 3) != 0);
        send_txn(m, f, fr, 1'b0, NO_DISPATCH);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("%0d transactions sent, %0d results checked, %0d errors",
             acc_cnt, res_cnt, err_cnt);
    $display("dispatches to lift one %0d, to lift two %0d, dropped requests %0d",
             to_one, to_two, drop_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
